/* hw/rtl/spq_pkg.sv */
// Shared types and codes for the stable priority queue.
package spq_pkg;

  localparam logic [1:0] FUNC_ENQ = 2'd0;
  localparam logic [1:0] FUNC_DEQ = 2'd1;
  localparam logic [1:0] FUNC_CLR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic enq;
    logic deq;
    logic clr;
  } ctrl_t;

endpackage

/* hw/rtl/stable_priority_queue_top.sv */
// Stable priority queue: chain of compare-and-shift cells with a registered result.
//
// Input channel (in_valid_i/in_ready_o) carries one word per operation:
// func_i selects enqueue, dequeue or clear; in_priority_i and in_data_i
// give the entry for an enqueue. Higher priority leaves first, equal
// priorities leave in arrival order. Output channel (out_valid_o/out_ready_i)
// returns one word per operation: status, the removed entry of a dequeue,
// the head after the operation, and the entry count.
// The result is registered and appears in the cycle after the operation is accepted.
// Throughput: one operation per cycle while each result is taken; every cell
// compares its stored priority against the new word and shifts in the same
// cycle, so the chain settles in a single step.
// Reset empties the queue and drops any pending result; slot contents are
// not cleared, only their valid bits.
// When the receiver stalls, the result register holds its word and the
// input is accepted only in a cycle where that word leaves.
// An enqueue into a full queue is refused with a full status; a dequeue on
// an empty queue returns an empty status with zero data.
module stable_priority_queue_top #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 4,
  parameter int DATA_BITS = 16,
  localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  logic [PRIO_BITS-1:0] in_priority_i,
  input  logic [DATA_BITS-1:0] in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [DATA_BITS-1:0] out_data_o,
  output logic [PRIO_BITS-1:0] out_priority_o,
  output logic                 head_valid_o,
  output logic [DATA_BITS-1:0] head_data_o,
  output logic [CNT_BITS-1:0]  count_o
);

  logic [DEPTH-1:0]     valid_w;
  logic [DEPTH-1:0]     keep_w;
  logic [DEPTH-1:0]     prev_valid_w;
  logic [DEPTH-1:0]     prev_keep_w;
  logic [DEPTH-1:0]     next_valid_w;
  logic [PRIO_BITS-1:0] prio_w      [DEPTH];
  logic [DATA_BITS-1:0] data_w      [DEPTH];
  logic [PRIO_BITS-1:0] prev_prio_w [DEPTH];
  logic [DATA_BITS-1:0] prev_data_w [DEPTH];
  logic [PRIO_BITS-1:0] next_prio_w [DEPTH];
  logic [DATA_BITS-1:0] next_data_w [DEPTH];

  spq_pkg::ctrl_t ctrl;

  logic                in_fire;
  logic                full, empty;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  logic                 out_valid_q;
  logic [1:0]           status_q, status_d;
  logic [DATA_BITS-1:0] rdata_q, rdata_d;
  logic [PRIO_BITS-1:0] rprio_q, rprio_d;
  logic                 hvalid_q, hvalid_d;
  logic [DATA_BITS-1:0] hdata_q, hdata_d;
  logic [DATA_BITS-1:0] hdata_raw;
  logic [CNT_BITS-1:0]  count_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign full  = (cnt_q == CNT_BITS'(DEPTH));
  assign empty = (cnt_q == '0);

  assign ctrl.enq = in_fire && (func_i == spq_pkg::FUNC_ENQ) && !full;
  assign ctrl.deq = in_fire && (func_i == spq_pkg::FUNC_DEQ) && !empty;
  assign ctrl.clr = in_fire && (func_i == spq_pkg::FUNC_CLR);

  // Cell 0 sees an always-valid, always-keeping neighbor so a new head lands there.
  assign prev_valid_w = {valid_w[DEPTH-2:0], 1'b1};
  assign prev_keep_w  = {keep_w[DEPTH-2:0], 1'b1};
  assign next_valid_w = {1'b0, valid_w[DEPTH-1:1]};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_prio_w[i] = '0;
      assign prev_data_w[i] = '0;
    end else begin : g_mid
      assign prev_prio_w[i] = prio_w[i-1];
      assign prev_data_w[i] = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_prio_w[i] = '0;
      assign next_data_w[i] = '0;
    end else begin : g_rest
      assign next_prio_w[i] = prio_w[i+1];
      assign next_data_w[i] = data_w[i+1];
    end

    spq_cell #(
      .PRIO_BITS (PRIO_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_prio_i   (in_priority_i),
      .new_data_i   (in_data_i),
      .prev_keep_i  (prev_keep_w[i]),
      .prev_valid_i (prev_valid_w[i]),
      .prev_prio_i  (prev_prio_w[i]),
      .prev_data_i  (prev_data_w[i]),
      .next_valid_i (next_valid_w[i]),
      .next_prio_i  (next_prio_w[i]),
      .next_data_i  (next_data_w[i]),
      .keep_o       (keep_w[i]),
      .valid_o      (valid_w[i]),
      .prio_o       (prio_w[i]),
      .data_o       (data_w[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.clr) begin
      cnt_d = '0;
    end else if (ctrl.enq) begin
      cnt_d = cnt_q + CNT_BITS'(1);
    end else if (ctrl.deq) begin
      cnt_d = cnt_q - CNT_BITS'(1);
    end
  end

  // Build the result word, with the head as it stands after the operation.
  always_comb begin
    status_d  = spq_pkg::ST_OK;
    rdata_d   = '0;
    rprio_d   = '0;
    hvalid_d  = valid_w[0];
    hdata_raw = data_w[0];
    case (func_i)
      spq_pkg::FUNC_ENQ: begin
        if (full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          hvalid_d  = 1'b1;
          hdata_raw = keep_w[0] ? data_w[0] : in_data_i;
        end
      end
      spq_pkg::FUNC_DEQ: begin
        if (empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          rdata_d   = data_w[0];
          rprio_d   = prio_w[0];
          hvalid_d  = valid_w[1];
          hdata_raw = data_w[1];
        end
      end
      spq_pkg::FUNC_CLR: begin
        hvalid_d = 1'b0;
      end
      default: begin
        hvalid_d = valid_w[0];
      end
    endcase
    hdata_d = hvalid_d ? hdata_raw : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result word until it is taken.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      rdata_q  <= rdata_d;
      rprio_q  <= rprio_d;
      hvalid_q <= hvalid_d;
      hdata_q  <= hdata_d;
      count_q  <= cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_data_o     = rdata_q;
  assign out_priority_o = rprio_q;
  assign head_valid_o   = hvalid_q;
  assign head_data_o    = hdata_q;
  assign count_o        = count_q;

`ifndef SYNTHESIS
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == int'(cnt_q))
    else $error("entry count differs from occupied cells");

  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w & (valid_w + DEPTH'(1))) == '0)
    else $error("occupied cells are not a contiguous run from the head");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while result word is stalled");

  a_deq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && func_i == spq_pkg::FUNC_DEQ && !empty)
      |=> (out_valid_o && status_o == spq_pkg::ST_OK && count_o == cnt_q))
    else $error("dequeue on a nonempty queue gave a bad result");
`endif

endmodule

/* hw/rtl/spq_cell.sv */
// One slot of the sorted chain: holds an entry, compares and shifts with its neighbors.
module spq_cell #(
  parameter int PRIO_BITS = 4,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spq_pkg::ctrl_t       ctrl_i,
  input  logic [PRIO_BITS-1:0] new_prio_i,
  input  logic [DATA_BITS-1:0] new_data_i,
  input  logic                 prev_keep_i,
  input  logic                 prev_valid_i,
  input  logic [PRIO_BITS-1:0] prev_prio_i,
  input  logic [DATA_BITS-1:0] prev_data_i,
  input  logic                 next_valid_i,
  input  logic [PRIO_BITS-1:0] next_prio_i,
  input  logic [DATA_BITS-1:0] next_data_i,
  output logic                 keep_o,
  output logic                 valid_o,
  output logic [PRIO_BITS-1:0] prio_o,
  output logic [DATA_BITS-1:0] data_o
);

  logic                 valid_q, valid_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic [DATA_BITS-1:0] data_q, data_d;
  logic                 keep;

  // Entries of equal or higher priority stay ahead of the new word.
  assign keep = valid_q && (prio_q >= new_prio_i);

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    data_d  = data_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.enq) begin
      valid_d = valid_q | prev_valid_i;
      if (keep) begin
        prio_d = prio_q;
        data_d = data_q;
      end else if (prev_keep_i) begin
        prio_d = new_prio_i;
        data_d = new_data_i;
      end else begin
        prio_d = prev_prio_i;
        data_d = prev_data_i;
      end
    end else if (ctrl_i.deq) begin
      valid_d = next_valid_i;
      prio_d  = next_prio_i;
      data_d  = next_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign keep_o  = keep;
  assign valid_o = valid_q;
  assign prio_o  = prio_q;
  assign data_o  = data_q;

endmodule

/* tb/sv/stable_priority_queue_top_test.sv */
// Testbench for the stable priority queue: directed and random operations checked against a model.
module stable_priority_queue_top_test;

  localparam int DEPTH       = 16;
  localparam int PRIO_W      = 4;
  localparam int DATA_W      = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RANDOM_OPS  = 1600;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;
  localparam int HOLD_LEN    = 150;
  localparam int CALM_START  = 1500;
  localparam int CALM_END    = 2000;

  // Unused operation code: the block must treat it as a no-op.
  localparam logic [1:0] FUNC_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } op_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] out_data;
    logic [PRIO_W-1:0] out_prio;
    logic              head_valid;
    logic [DATA_W-1:0] head_data;
    logic [CNT_W-1:0]  count;
  } result_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        func_i        = spq_pkg::FUNC_ENQ;
  logic [PRIO_W-1:0] in_priority_i = '0;
  logic [DATA_W-1:0] in_data_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [1:0]        status_o;
  logic [DATA_W-1:0] out_data_o;
  logic [PRIO_W-1:0] out_priority_o;
  logic              head_valid_o;
  logic [DATA_W-1:0] head_data_o;
  logic [CNT_W-1:0]  count_o;

  op_t     pending_ops[$];
  result_t predicted_results[$];

  // Model of the sorted slots, head at index 0.
  logic [PRIO_W-1:0] slot_prio[DEPTH];
  logic [DATA_W-1:0] slot_data[DEPTH];
  int                slot_count = 0;

  int cycle_cnt  = 0;
  int mismatches = 0;
  int hold_left  = 0;
  int n_enq = 0, n_full = 0, n_deq = 0, n_empty = 0, n_clr = 0, n_nop = 0;
  int peak_count = 0, n_results = 0;
  logic calm;

  assign calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);

  stable_priority_queue_top #(
    .DEPTH    (DEPTH),
    .PRIO_BITS(PRIO_W),
    .DATA_BITS(DATA_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .in_priority_i (in_priority_i),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_data_o    (out_data_o),
    .out_priority_o(out_priority_o),
    .head_valid_o  (head_valid_o),
    .head_data_o   (head_data_o),
    .count_o       (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               predicted_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_op(input logic [1:0] func, input logic [PRIO_W-1:0] prio,
                        input logic [DATA_W-1:0] data);
    op_t op;
    op.func = func;
    op.prio = prio;
    op.data = data;
    pending_ops.push_back(op);
  endtask

  // Apply one accepted operation to the sorted model and queue the word it must return.
  task automatic predict_queue_op(input logic [1:0] func, input logic [PRIO_W-1:0] prio,
                                  input logic [DATA_W-1:0] data);
    result_t r;
    int      pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    case (func)
      spq_pkg::FUNC_ENQ: begin
        n_enq++;
        if (slot_count >= DEPTH) begin
          r.status = spq_pkg::ST_FULL;
          n_full++;
        end else begin
          // Insert behind every entry of equal or higher priority.
          pos = 0;
          while (pos < slot_count && slot_prio[pos] >= prio) pos++;
          for (int k = slot_count; k > pos; k--) begin
            slot_prio[k] = slot_prio[k-1];
            slot_data[k] = slot_data[k-1];
          end
          slot_prio[pos] = prio;
          slot_data[pos] = data;
          slot_count++;
        end
      end
      spq_pkg::FUNC_DEQ: begin
        n_deq++;
        if (slot_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.out_data = slot_data[0];
          r.out_prio = slot_prio[0];
          for (int k = 1; k < slot_count; k++) begin
            slot_prio[k-1] = slot_prio[k];
            slot_data[k-1] = slot_data[k];
          end
          slot_count--;
        end
      end
      spq_pkg::FUNC_CLR: begin
        n_clr++;
        slot_count = 0;
      end
      default: n_nop++;
    endcase
    if (slot_count > peak_count) peak_count = slot_count;
    r.head_valid = (slot_count > 0);
    r.head_data  = (slot_count > 0) ? slot_data[0] : '0;
    r.count      = slot_count[CNT_W-1:0];
    predicted_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Sender: present the next word once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    op_t nxt;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      func_i        <= spq_pkg::FUNC_ENQ;
      in_priority_i <= '0;
      in_data_i     <= '0;
    end else begin
      if (in_valid_i && in_ready_o) predict_queue_op(func_i, in_priority_i, in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          nxt = pending_ops.pop_front();
          in_valid_i    <= 1'b1;
          func_i        <= nxt.func;
          in_priority_i <= nxt.prio;
          in_data_i     <= nxt.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus two long hold-offs that back up the input.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (cycle_cnt == 150 || cycle_cnt == 1200) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_LEN;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result word, status %0h count %0h", $time, status_o,
                 count_o);
        mismatches++;
      end else begin
        exp_r = predicted_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(status_o));
        check_field("out_data", 32'(exp_r.out_data), 32'(out_data_o));
        check_field("out_priority", 32'(exp_r.out_prio), 32'(out_priority_o));
        check_field("head_valid", 32'(exp_r.head_valid), 32'(head_valid_o));
        check_field("head_data", 32'(exp_r.head_data), 32'(head_data_o));
        check_field("count", 32'(exp_r.count), 32'(count_o));
      end
    end
  end

  initial begin : stimulus
    int seg_len;
    int enq_bias;
    int tie_mode;
    int added;
    int roll;

    // Directed: empty cases, no-op, ties at head and tail, fill, refuse, drain.
    add_op(spq_pkg::FUNC_DEQ, 4'h0, 16'h0000);
    add_op(spq_pkg::FUNC_CLR, 4'h0, 16'h0000);
    add_op(FUNC_NOP, 4'hF, 16'hFFFF);
    add_op(spq_pkg::FUNC_ENQ, 4'h0, 16'h0000);
    add_op(spq_pkg::FUNC_ENQ, 4'hF, 16'hFFFF);
    add_op(spq_pkg::FUNC_ENQ, 4'h7, 16'h1111);
    add_op(spq_pkg::FUNC_ENQ, 4'h7, 16'h2222);
    add_op(spq_pkg::FUNC_ENQ, 4'h7, 16'h3333);
    add_op(spq_pkg::FUNC_ENQ, 4'hF, 16'hAAAA);
    add_op(spq_pkg::FUNC_ENQ, 4'h0, 16'h5555);
    for (int i = 0; i < 9; i++) begin
      add_op(spq_pkg::FUNC_ENQ, PRIO_W'(i + 3), DATA_W'(16'h0100 + i));
    end
    add_op(spq_pkg::FUNC_ENQ, 4'h8, 16'hBEEF);
    repeat (3) add_op(spq_pkg::FUNC_DEQ, 4'h0, 16'h0000);
    add_op(spq_pkg::FUNC_CLR, 4'h0, 16'h0000);
    add_op(spq_pkg::FUNC_DEQ, 4'h0, 16'h0000);

    // Random: segments that lean toward filling or draining or stay balanced, often with crowded priorities.
    added = 0;
    while (added < RANDOM_OPS) begin
      seg_len  = $urandom_range(4, 40);
      roll     = $urandom_range(0, 2);
      enq_bias = (roll == 0) ? 85 : (roll == 1) ? 50 : 15;
      tie_mode = $urandom_range(0, 1);
      for (int i = 0; i < seg_len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 1) begin
          add_op(FUNC_NOP, PRIO_W'($urandom), DATA_W'($urandom));
        end else begin
          if (roll < 2) add_op(spq_pkg::FUNC_CLR, PRIO_W'($urandom), DATA_W'($urandom));
          else if ($urandom_range(0, 99) < enq_bias)
            add_op(spq_pkg::FUNC_ENQ,
                   tie_mode ? PRIO_W'($urandom_range(0, 2)) : PRIO_W'($urandom),
                   DATA_W'($urandom));
          else add_op(spq_pkg::FUNC_DEQ, PRIO_W'($urandom), DATA_W'($urandom));
          added++;
        end
      end
    end

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || in_valid_i) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Checked %0d result words: %0d enqueues (%0d refused full), %0d dequeues",
             n_results, n_enq, n_full, n_deq);
    $display("  (%0d on empty), %0d clears, %0d no-ops, peak occupancy %0d of %0d",
             n_empty, n_clr, n_nop, peak_count, DEPTH);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
